[src/cmas_pkg.sv]
// ============================================================================
// cmas_pkg - shared constants and types of the cascaded moving-average smoother
// Holds the widths, configuration register indexes and reset values used by
// the smoother core and its scaling unit.
// ============================================================================
`default_nettype none

package cmas_pkg;

    // Longest window of the first two averaging stages
    localparam int MAX_PERIOD  = 64;
    localparam int SAMPLE_W    = 16;

    // Ring pointer and effective period widths
    localparam int PTR_W       = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam int EP_W        = $clog2(MAX_PERIOD + 1);

    // Running window sums: each stage grows by the log of its window length
    localparam int S1_W        = SAMPLE_W + PTR_W;
    localparam int S2_W        = S1_W + PTR_W;
    localparam int S3_W        = S2_W + 2;

    // Sample counter: must reach at least 2*MAX_PERIOD before it saturates
    localparam int COUNT_W     = $clog2(2 * MAX_PERIOD) + 1;
    localparam int CMP_W       = COUNT_W + 1;

    // Configuration registers
    localparam int PERIOD_W    = 7;
    localparam int RECIP_W     = 23;
    localparam int CFG_W       = RECIP_W;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP  = 1'b1;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 7'd2;
    localparam logic [RECIP_W-1:0]  RECIP_RST  = 23'd1398101;

    // Output scaling: reciprocal is a fraction with this many bits
    localparam int SCALE_SHIFT = 24;
    localparam int OUT_W       = 16;
    localparam int PROD_W      = S3_W + RECIP_W + 1;
    localparam int Q_W         = PROD_W - SCALE_SHIFT;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [S1_W-1:0]     t_sum1;
    typedef logic signed [S2_W-1:0]     t_sum2;
    typedef logic signed [S3_W-1:0]     t_sum3;
    typedef logic signed [OUT_W-1:0]    t_out;

    // Bypass control for a history RAM read that collides with a write
    typedef struct packed {
        logic               hit;
        logic [PTR_W-1:0]   addr;
    } t_byp;

endpackage

`default_nettype wire

[src/cmas_ram.sv]
// ============================================================================
// cmas_ram - generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module cmas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_we,
    input  wire logic [$clog2(DEPTH)-1:0]          i_waddr,
    input  wire logic [WIDTH-1:0]                  i_wdata,
    input  wire logic                              i_re,
    input  wire logic [$clog2(DEPTH)-1:0]          i_raddr,
    output      logic [WIDTH-1:0]                  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/cmas_scale.sv]
// ============================================================================
// cmas_scale - triple-sum scaling unit
// Multiply the triple window sum by the reciprocal, round to nearest and
// saturate to signed Q8.8.
// ============================================================================
`default_nettype none

module cmas_scale (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire cmas_pkg::t_sum3                   i_sum,
    input  wire logic [cmas_pkg::RECIP_W-1:0]      i_recip,
    output      cmas_pkg::t_out                    o_value
);

    localparam logic signed [cmas_pkg::PROD_W-1:0] HALF =
        cmas_pkg::PROD_W'(1) <<< (cmas_pkg::SCALE_SHIFT - 1);
    localparam logic signed [cmas_pkg::Q_W-1:0] Q_MAX =
        cmas_pkg::Q_W'((2 ** (cmas_pkg::OUT_W - 1)) - 1);
    localparam logic signed [cmas_pkg::Q_W-1:0] Q_MIN =
        -cmas_pkg::Q_W'(2 ** (cmas_pkg::OUT_W - 1));

    logic signed [cmas_pkg::PROD_W-1:0] w_prod;
    logic signed [cmas_pkg::PROD_W-1:0] w_round;
    logic signed [cmas_pkg::Q_W-1:0]    w_q;
    cmas_pkg::t_out                     n_value;
    cmas_pkg::t_out                     r_value;

    assign w_prod  = cmas_pkg::PROD_W'(i_sum) *
                     cmas_pkg::PROD_W'($signed({1'b0, i_recip}));
    assign w_round = w_prod + HALF;
    // arithmetic shift: floor towards minus infinity
    assign w_q     = w_round[cmas_pkg::PROD_W-1:cmas_pkg::SCALE_SHIFT];

    always_comb begin
        if (w_q > Q_MAX) begin
            n_value = Q_MAX[cmas_pkg::OUT_W-1:0];
        end else if (w_q < Q_MIN) begin
            n_value = Q_MIN[cmas_pkg::OUT_W-1:0];
        end else begin
            n_value = w_q[cmas_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

[src/cascaded_moving_average_smoother_core.sv]
// ============================================================================
// cascaded_moving_average_smoother_core - three cascaded moving averages
// Smooth one series with windows of period, period and 3 using exact running
// sums, then scale by a programmed reciprocal to a rounded, saturated Q8.8.
// ============================================================================
//
//  Channel      Direction  Transaction carries
//  s_axis_*     in         tdata[15:0] = sample (Q8.8), tlast = last of series
//  m_axis_*     out        tdata[15:0] = smoothed (Q8.8), tlast = last_res
//  i_cfg_*      in         idx 0 = period (7 b), idx 1 = scale_reciprocal (23 b)
//
//  One sample per cycle while m_axis is not held; a sample passes the input,
//  sum and scaling registers in turn on its way to m_axis, and the history
//  RAMs take one read and one write per sample.
//  Reset is synchronous and clears control and sums; RAM contents are kept.
//  Back-pressure on m_axis holds the output register; an earlier stage holds
//  only while the stage after it is full and held, so bubbles close up.
//
`default_nettype none

module cascaded_moving_average_smoother_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [cmas_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [cmas_pkg::CFG_W-1:0]        i_cfg_data,
    // sample stream
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    input  wire logic [cmas_pkg::SAMPLE_W-1:0]     s_axis_tdata,  // [15:0] sample
    input  wire logic                              s_axis_tlast,
    // result stream
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output      logic [cmas_pkg::OUT_W-1:0]        m_axis_tdata,  // [15:0] smoothed
    output      logic                              m_axis_tlast
);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [cmas_pkg::PERIOD_W-1:0] r_period;
    logic [cmas_pkg::RECIP_W-1:0]  r_recip;
    logic                          w_cfg_period;

    assign w_cfg_period = i_cfg_we && (i_cfg_idx == cmas_pkg::CFG_PERIOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= cmas_pkg::PERIOD_RST;
            r_recip  <= cmas_pkg::RECIP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cmas_pkg::CFG_PERIOD: r_period <= i_cfg_data[cmas_pkg::PERIOD_W-1:0];
                cmas_pkg::CFG_RECIP:  r_recip  <= i_cfg_data[cmas_pkg::RECIP_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective period: zero acts as one, clamp to the ring depth
    logic [cmas_pkg::EP_W-1:0] w_p;

    always_comb begin
        if (r_period == '0) begin
            w_p = cmas_pkg::EP_W'(1);
        end else if (int'(r_period) > cmas_pkg::MAX_PERIOD) begin
            w_p = cmas_pkg::EP_W'(cmas_pkg::MAX_PERIOD);
        end else begin
            w_p = cmas_pkg::EP_W'(r_period);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    logic w_out_adv;
    logic w_s2_adv;
    logic w_s1_adv;
    logic w_in_acc;
    logic w_emit;

    assign w_out_adv     = !r_out_valid || m_axis_tready;
    assign w_s2_adv      = r_s2_valid && w_out_adv;
    assign w_s1_adv      = r_s1_valid && (!r_s2_valid || w_out_adv);
    assign s_axis_tready = !r_s1_valid || w_s1_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    cmas_pkg::t_sample r_s1_x;
    logic              r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_x    <= s_axis_tdata;
            r_s1_last <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Series state
    // ------------------------------------------------------------------
    cmas_pkg::t_sum1              r_first;
    cmas_pkg::t_sum2              r_second;
    cmas_pkg::t_sum3              r_third;
    logic [cmas_pkg::COUNT_W-1:0] r_count;
    logic [cmas_pkg::PTR_W-1:0]   r_ptr;
    logic [1:0]                   r_phase;
    cmas_pkg::t_sum2              r_hist2 [3];

    cmas_pkg::t_sum1              n_first;
    cmas_pkg::t_sum2              n_second;
    cmas_pkg::t_sum3              n_third;
    logic [cmas_pkg::COUNT_W-1:0] n_count;
    logic [cmas_pkg::PTR_W-1:0]   n_ptr;
    logic [1:0]                   n_phase;

    // ------------------------------------------------------------------
    // History rings: read issued when a sample is taken, at the pointer it
    // will use; written when it leaves stage 1
    // ------------------------------------------------------------------
    cmas_pkg::t_sample ram_x_rdata;
    cmas_pkg::t_sum1   ram_c1_rdata;
    cmas_pkg::t_sum1   w_c1;
    cmas_pkg::t_byp    w_byp;
    logic              r_byp_hit;
    cmas_pkg::t_sample r_byp_x;
    cmas_pkg::t_sum1   r_byp_c1;

    cmas_ram #(
        .WIDTH (cmas_pkg::SAMPLE_W),
        .DEPTH (cmas_pkg::MAX_PERIOD)
    ) u_hist_x (
        .i_clk   (i_clk),
        .i_we    (w_s1_adv),
        .i_waddr (r_ptr),
        .i_wdata (r_s1_x),
        .i_re    (w_in_acc),
        .i_raddr (n_ptr),
        .o_rdata (ram_x_rdata)
    );

    cmas_ram #(
        .WIDTH (cmas_pkg::S1_W),
        .DEPTH (cmas_pkg::MAX_PERIOD)
    ) u_hist_c1 (
        .i_clk   (i_clk),
        .i_we    (w_s1_adv),
        .i_waddr (r_ptr),
        .i_wdata (w_c1),
        .i_re    (w_in_acc),
        .i_raddr (n_ptr),
        .o_rdata (ram_c1_rdata)
    );

    // Read and write at the same edge and address: forward the new data
    assign w_byp.addr = r_ptr;
    assign w_byp.hit  = w_in_acc && w_s1_adv && (n_ptr == w_byp.addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else if (w_in_acc) begin
            r_byp_hit <= w_byp.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_byp_x  <= r_s1_x;
            r_byp_c1 <= w_c1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 arithmetic: update the three running sums
    // ------------------------------------------------------------------
    logic [cmas_pkg::CMP_W-1:0] w_t;
    logic [cmas_pkg::CMP_W-1:0] w_pc;
    logic                       w_full1;
    logic                       w_feed1;
    logic                       w_feed2;
    logic                       w_full3;
    cmas_pkg::t_sample          w_old_x;
    cmas_pkg::t_sum1            w_old_c1;
    cmas_pkg::t_sum2            w_old_c2;
    cmas_pkg::t_sum2            w_c2;
    logic [cmas_pkg::EP_W:0]    w_ptr_inc;

    assign w_t     = cmas_pkg::CMP_W'(r_count);
    assign w_pc    = cmas_pkg::CMP_W'(w_p);
    assign w_full1 = w_t >= w_pc;
    assign w_feed1 = (w_t + cmas_pkg::CMP_W'(1)) >= w_pc;
    assign w_feed2 = (w_t + cmas_pkg::CMP_W'(2)) >= (w_pc << 1);
    assign w_full3 = w_t >= cmas_pkg::CMP_W'(3);
    assign w_emit  = w_t >= (w_pc << 1);

    assign w_old_x  = !w_full1  ? '0 : (r_byp_hit ? r_byp_x  : ram_x_rdata);
    assign w_old_c1 = !w_full1  ? '0 : (r_byp_hit ? r_byp_c1 : ram_c1_rdata);
    assign w_old_c2 = !w_full3  ? '0 : r_hist2[r_phase];

    assign n_first  = r_first + cmas_pkg::t_sum1'(r_s1_x) - cmas_pkg::t_sum1'(w_old_x);
    assign w_c1     = w_feed1 ? n_first : '0;
    assign n_second = r_second + cmas_pkg::t_sum2'(w_c1) - cmas_pkg::t_sum2'(w_old_c1);
    assign w_c2     = w_feed2 ? n_second : '0;
    assign n_third  = r_third + cmas_pkg::t_sum3'(w_c2) - cmas_pkg::t_sum3'(w_old_c2);

    assign w_ptr_inc = (cmas_pkg::EP_W + 1)'(r_ptr) + 1'b1;

    // Next pointer, phase and count, including a clear after the last sample or a period write
    always_comb begin
        n_ptr   = r_ptr;
        n_phase = r_phase;
        n_count = r_count;
        if (w_s1_adv) begin
            if (r_s1_last) begin
                n_ptr   = '0;
                n_phase = '0;
                n_count = '0;
            end else begin
                n_ptr   = (w_ptr_inc >= (cmas_pkg::EP_W + 1)'(w_p)) ? '0
                        : w_ptr_inc[cmas_pkg::PTR_W-1:0];
                n_phase = (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
                n_count = (r_count == '1) ? r_count : r_count + 1'b1;
            end
        end
        if (w_cfg_period) begin
            n_ptr   = '0;
            n_phase = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_second <= '0;
            r_third  <= '0;
            r_count  <= '0;
            r_ptr    <= '0;
            r_phase  <= '0;
        end else begin
            r_count <= n_count;
            r_ptr   <= n_ptr;
            r_phase <= n_phase;
            if (w_cfg_period || (w_s1_adv && r_s1_last)) begin
                r_first  <= '0;
                r_second <= '0;
                r_third  <= '0;
            end else if (w_s1_adv) begin
                r_first  <= n_first;
                r_second <= n_second;
                r_third  <= n_third;
            end
        end
    end

    // Window-3 ring: hold the last three second-stage contributions
    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_hist2[r_phase] <= w_c2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: triple sum register, then scaling into the output register
    // ------------------------------------------------------------------
    cmas_pkg::t_sum3 r_s2_sum;
    logic            r_s2_last;
    logic            r_out_last;
    cmas_pkg::t_out  w_scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_s2_valid <= w_emit;
        end else if (w_s2_adv) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s2_sum  <= n_third;
            r_s2_last <= r_s1_last;
        end
    end

    cmas_scale u_scale (
        .i_clk   (i_clk),
        .i_en    (w_s2_adv),
        .i_sum   (r_s2_sum),
        .i_recip (r_recip),
        .o_value (w_scaled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_adv) begin
            r_out_last <= r_s2_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = w_scaled;
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ptr_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmas_pkg::EP_W + 1)'(r_ptr) < (cmas_pkg::EP_W + 1)'(w_p))
        else $error("ring pointer outside the active window");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && r_s1_last) |=> (r_count == '0 && r_first == '0 && r_ptr == '0))
        else $error("series state not cleared after final sample");

    a_period_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_period |=> (r_count == '0 && r_third == '0))
        else $error("period write did not clear series state");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && !w_emit) |=> !r_s2_valid)
        else $error("result raised before the windows filled");

endmodule

`default_nettype wire
